[design/yti_pkg.sv]
// ----------------------------------------------------------------------------
// yti_pkg
// Shared types and constants of the YUYV to I420 mirroring converter.
// ----------------------------------------------------------------------------
package yti_pkg;

    localparam int MAX_PAIRS_DEF = 1024;
    localparam int MAX_LINES_DEF = 2048;

    localparam int PAIR_CNT_W = 11;
    localparam int LINE_CNT_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_W      = 11;
    localparam int PAIR_W     = 10;
    localparam int PIX_W      = 8;
    localparam int CHROMA_W   = 2 * PIX_W;

    localparam logic [PAIR_CNT_W-1:0] PAIR_CNT_RST = PAIR_CNT_W'(320);
    localparam logic [LINE_CNT_W-1:0] LINE_CNT_RST = LINE_CNT_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR_COUNT,
        CFG_LINE_COUNT,
        CFG_MIRROR_H,
        CFG_MIRROR_V
    } yti_cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_red;
    } yti_in_t;

    typedef struct packed {
        logic [ROW_W-1:0]  out_row;
        logic [PAIR_W-1:0] out_pair;
        logic [PIX_W-1:0]  luma_left;
        logic [PIX_W-1:0]  luma_right;
        logic              chroma_valid;
        logic [PIX_W-1:0]  cb_avg;
        logic [PIX_W-1:0]  cr_avg;
        logic              frame_end;
    } yti_out_t;

    typedef struct packed {
        logic avg;
        logic lone;
        logic frame_end;
    } yti_ctl_t;

endpackage

[design/yti_line_mem.sv]
// ----------------------------------------------------------------------------
// yti_line_mem
// One-line chroma store, {Cb, Cr} per pair column, registered read.
// ----------------------------------------------------------------------------
module yti_line_mem import yti_pkg::*; #(
    parameter int DEPTH = MAX_PAIRS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic                rd_en,
    input  logic [AW-1:0]       addr,
    input  logic [CHROMA_W-1:0] wr_data,
    output logic [CHROMA_W-1:0] rd_data
);

    logic [CHROMA_W-1:0] mem [DEPTH];
    logic [CHROMA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/yti_seq.sv]
// ----------------------------------------------------------------------------
// yti_seq
// Source column and line counters, line pairing and store access control.
// ----------------------------------------------------------------------------
module yti_seq import yti_pkg::*; #(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF,
    parameter int MAX_LINES = MAX_LINES_DEF,
    parameter int PCW       = 12,
    parameter int LCW       = 12,
    parameter int CW        = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1,
    parameter int RW        = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           take,
    input  logic [PCW-1:0] pairs,
    input  logic [LCW-1:0] lines,
    input  logic           vflip,
    output logic [CW-1:0]  col,
    output logic [RW-1:0]  row,
    output yti_ctl_t       ctl,
    output logic           mem_wr,
    output logic           mem_rd
);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          last_col, last_row, odd_h, shift, lone, parity;

    always_comb begin
        col      = (PCW'(col_reg) >= pairs) ? '0 : col_reg;
        row      = (LCW'(row_reg) >= lines) ? '0 : row_reg;
        last_col = (PCW'(col) == pairs - PCW'(1));
        last_row = (LCW'(row) == lines - LCW'(1));
        odd_h    = lines[0];
        shift    = vflip & odd_h;
        lone     = shift ? (row == '0) : (odd_h & last_row);
        parity   = row[0] ^ shift;

        ctl.avg       = ~lone & parity;
        ctl.lone      = lone;
        ctl.frame_end = last_col & last_row;

        mem_wr = take & ~lone & ~parity;
        mem_rd = take & ~lone & parity;

        col_next = col_reg;
        row_next = row_reg;
        if (take) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row + RW'(1);
            end else begin
                col_next = col + CW'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_no_wr_rd_same: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr && mem_rd))
        else $error("store written and read by one transfer");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        take && ctl.frame_end |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap after frame end");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !last_col |=> PCW'(col_reg) < pairs)
        else $error("column counter beyond pair count");

endmodule

[design/yti_out.sv]
// ----------------------------------------------------------------------------
// yti_out
// Store-read stage and output register: mirroring, chroma averaging, flow.
// ----------------------------------------------------------------------------
module yti_out import yti_pkg::*; #(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF,
    parameter int MAX_LINES = MAX_LINES_DEF,
    parameter int PCW       = 12,
    parameter int LCW       = 12,
    parameter int CW        = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1,
    parameter int RW        = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  yti_in_t             item,
    input  logic [CW-1:0]       col,
    input  logic [RW-1:0]       row,
    input  yti_ctl_t            ctl,
    input  logic [CHROMA_W-1:0] rd_data,
    input  logic [PCW-1:0]      pairs,
    input  logic [LCW-1:0]      lines,
    input  logic                hflip,
    input  logic                vflip,
    output logic                in_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output yti_out_t            m_data
);

    logic          s1_valid_reg, s1_valid_next;
    yti_in_t       s1_item_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    yti_ctl_t      s1_ctl_reg;

    logic          m_valid_reg, m_valid_next;
    yti_out_t      m_data_reg, m_data_next;

    logic           out_free, advance;
    logic [LCW-1:0] orow;
    logic [PCW-1:0] opair;
    logic [PIX_W:0] cb_sum, cr_sum;

    always_comb begin
        out_free = ~m_valid_reg | m_ready;
        advance  = s1_valid_reg & out_free;
        in_ready = ~s1_valid_reg | out_free;

        s1_valid_next = take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        m_valid_next  = advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

        orow  = vflip ? (lines - LCW'(1) - LCW'(s1_row_reg)) : LCW'(s1_row_reg);
        opair = hflip ? (pairs - PCW'(1) - PCW'(s1_col_reg)) : PCW'(s1_col_reg);

        cb_sum = {1'b0, rd_data[CHROMA_W-1:PIX_W]} + {1'b0, s1_item_reg.chroma_blue};
        cr_sum = {1'b0, rd_data[PIX_W-1:0]} + {1'b0, s1_item_reg.chroma_red};

        m_data_next.out_row   = ROW_W'(orow);
        m_data_next.out_pair  = PAIR_W'(opair);
        m_data_next.luma_left  = hflip ? s1_item_reg.luma_second : s1_item_reg.luma_first;
        m_data_next.luma_right = hflip ? s1_item_reg.luma_first : s1_item_reg.luma_second;
        m_data_next.chroma_valid = s1_ctl_reg.avg | s1_ctl_reg.lone;
        m_data_next.frame_end    = s1_ctl_reg.frame_end;
        if (s1_ctl_reg.lone) begin
            m_data_next.cb_avg = s1_item_reg.chroma_blue;
            m_data_next.cr_avg = s1_item_reg.chroma_red;
        end else if (s1_ctl_reg.avg) begin
            m_data_next.cb_avg = cb_sum[PIX_W:1];
            m_data_next.cr_avg = cr_sum[PIX_W:1];
        end else begin
            m_data_next.cb_avg = '0;
            m_data_next.cr_avg = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_item_reg <= item;
            s1_col_reg  <= col;
            s1_row_reg  <= row;
            s1_ctl_reg  <= ctl;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_take_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> s1_valid_reg)
        else $error("accepted transfer lost before store-read stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("store-read stage dropped while output stalled");

    a_take_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> !s1_valid_reg || advance)
        else $error("store-read stage overwritten");

endmodule

[design/yuyv_to_i420_mirror_converter.sv]
// ----------------------------------------------------------------------------
// yuyv_to_i420_mirror_converter
// YUYV macropixel stream to planar 4:2:0 luma pairs and averaged chroma,
// with optional horizontal and vertical mirroring.
// ----------------------------------------------------------------------------
// One macropixel is taken per clock unless m_ready stalls the output. Each
// gives one result via the synchronous read of the one-line chroma store, then
// the output register. The store is read or written at most once per transfer,
// at the source pair column: written on a vertical pair's first line, read on
// its second. Configuration is written through cfg_wr_en/cfg_index/cfg_data by
// the user only while no transfer is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module yuyv_to_i420_mirror_converter import yti_pkg::*; #(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF,
    parameter int MAX_LINES = MAX_LINES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  yti_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output yti_out_t              m_data
);

    localparam int NPW = $clog2(MAX_PAIRS + 1);
    localparam int NLW = $clog2(MAX_LINES + 1);
    localparam int PCW = (NPW > PAIR_CNT_W) ? NPW : PAIR_CNT_W;
    localparam int LCW = (NLW > LINE_CNT_W) ? NLW : LINE_CNT_W;
    localparam int CW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int RW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    logic [PAIR_CNT_W-1:0] pair_count_reg;
    logic [LINE_CNT_W-1:0] line_count_reg;
    logic                  hflip_reg, vflip_reg;

    logic [PCW-1:0]      pcnt, pairs;
    logic [LCW-1:0]      lcnt, lines;
    logic                take, in_ready;
    logic [CW-1:0]       col;
    logic [RW-1:0]       row;
    yti_ctl_t            ctl;
    logic                mem_wr, mem_rd;
    logic [CHROMA_W-1:0] rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_count_reg <= PAIR_CNT_RST;
            line_count_reg <= LINE_CNT_RST;
            hflip_reg      <= 1'b0;
            vflip_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (yti_cfg_idx_t'(cfg_index))
                CFG_PAIR_COUNT: pair_count_reg <= cfg_data[PAIR_CNT_W-1:0];
                CFG_LINE_COUNT: line_count_reg <= cfg_data[LINE_CNT_W-1:0];
                CFG_MIRROR_H:   hflip_reg      <= cfg_data[0];
                CFG_MIRROR_V:   vflip_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pcnt  = PCW'(pair_count_reg);
        lcnt  = LCW'(line_count_reg);
        pairs = (pcnt == '0) ? PCW'(1) : ((pcnt > PCW'(MAX_PAIRS)) ? PCW'(MAX_PAIRS) : pcnt);
        lines = (lcnt == '0) ? LCW'(1) : ((lcnt > LCW'(MAX_LINES)) ? LCW'(MAX_LINES) : lcnt);
    end

    assign s_ready = in_ready;
    assign take    = s_valid & in_ready;

    yti_seq #(
        .MAX_PAIRS (MAX_PAIRS),
        .MAX_LINES (MAX_LINES),
        .PCW       (PCW),
        .LCW       (LCW),
        .CW        (CW),
        .RW        (RW)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .pairs    (pairs),
        .lines    (lines),
        .vflip    (vflip_reg),
        .col      (col),
        .row      (row),
        .ctl      (ctl),
        .mem_wr   (mem_wr),
        .mem_rd   (mem_rd)
    );

    yti_line_mem #(
        .DEPTH (MAX_PAIRS),
        .AW    (CW)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .rd_en   (mem_rd),
        .addr    (col),
        .wr_data ({s_data.chroma_blue, s_data.chroma_red}),
        .rd_data (rd_data)
    );

    yti_out #(
        .MAX_PAIRS (MAX_PAIRS),
        .MAX_LINES (MAX_LINES),
        .PCW       (PCW),
        .LCW       (LCW),
        .CW        (CW),
        .RW        (RW)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .item     (s_data),
        .col      (col),
        .row      (row),
        .ctl      (ctl),
        .rd_data  (rd_data),
        .pairs    (pairs),
        .lines    (lines),
        .hflip    (hflip_reg),
        .vflip    (vflip_reg),
        .in_ready (in_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
